@@ hdl/pqp_pkg.sv @@
package pqp_pkg;

  localparam int unsigned ChanW     = 8;
  localparam int unsigned IdxW      = 2;
  localparam int unsigned NumColors = 4;
  localparam int unsigned NumChans  = 3;
  localparam int unsigned SqW       = 2 * ChanW;
  localparam int unsigned RadW      = SqW + 2;
  localparam int unsigned RootW     = RadW / 2;
  localparam int unsigned RemW      = RootW + 1;
  localparam int unsigned RootSteps = RootW;
  localparam int unsigned StepW     = $clog2(RootSteps);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned PendW     = 6;
  localparam int unsigned PendCntW  = 2;
  localparam int unsigned ByteW     = 8;

  // channel selectors for the palette lookup
  localparam logic [1:0] ChRed   = 2'd0;
  localparam logic [1:0] ChGreen = 2'd1;
  localparam logic [1:0] ChBlue  = 2'd2;

  localparam logic PalTexture = 1'b0;
  localparam logic PalSprite  = 1'b1;

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic            last;
  } pqp_entry_t;

  function automatic logic [ChanW-1:0] pal_chan(logic mode, logic [IdxW-1:0] n,
                                                logic [1:0] ch);
    logic [ChanW-1:0] val;
    case (n)
      2'd0: begin
        if (mode == PalSprite) begin
          val = (ch == ChRed) ? 8'd0 : 8'd255;
        end else begin
          val = 8'd191;
        end
      end
      2'd1: val = 8'd255;
      2'd2: val = 8'd0;
      2'd3: val = 8'd127;
      default: val = 8'd0;
    endcase
    return val;
  endfunction

endpackage

@@ hdl/pqp_front.sv @@
module pqp_front
  import pqp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             palette_mode_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ChanW-1:0] red_i,
  input  logic [ChanW-1:0] green_i,
  input  logic [ChanW-1:0] blue_i,
  input  logic             end_of_image_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output pqp_entry_t       push_data_o
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_SQR  = 5'b00010,
    F_SUM  = 5'b00100,
    F_ROOT = 5'b01000,
    F_PICK = 5'b10000
  } front_state_e;

  front_state_e state_q, state_d;
  logic [StepW-1:0] step_q, step_d;

  logic [ChanW-1:0] pix_q [NumChans];
  logic             last_q;
  logic [SqW-1:0]   sq_q   [NumColors][NumChans];
  logic [SqW-1:0]   sq_d   [NumColors][NumChans];
  logic [RadW-1:0]  rad_q  [NumColors];
  logic [RadW-1:0]  rad_d  [NumColors];
  logic [RemW-1:0]  rem_q  [NumColors];
  logic [RemW-1:0]  rem_d  [NumColors];
  logic [RootW-1:0] root_q [NumColors];
  logic [RootW-1:0] root_d [NumColors];
  logic [IdxW-1:0]  best_idx;

  // squared channel distances for all four colours
  always_comb begin
    logic [ChanW-1:0] pc;
    logic [ChanW-1:0] diff;
    for (int n = 0; n < NumColors; n++) begin
      for (int c = 0; c < NumChans; c++) begin
        pc   = pal_chan(palette_mode_i, IdxW'(n), 2'(c));
        diff = (pc > pix_q[c]) ? pc - pix_q[c] : pix_q[c] - pc;
        sq_d[n][c] = SqW'(diff) * SqW'(diff);
      end
    end
  end

  // one root bit per cycle in every lane
  always_comb begin
    logic [RemW+1:0] rem_pre;
    logic [RemW+1:0] trial;
    for (int n = 0; n < NumColors; n++) begin
      rem_pre = {rem_q[n], rad_q[n][RadW-1 -: 2]};
      trial   = {1'b0, root_q[n], 2'b01};
      rad_d[n] = {rad_q[n][RadW-3:0], 2'b00};
      if (rem_pre >= trial) begin
        rem_d[n]  = RemW'(rem_pre - trial);
        root_d[n] = {root_q[n][RootW-2:0], 1'b1};
      end else begin
        rem_d[n]  = rem_pre[RemW-1:0];
        root_d[n] = {root_q[n][RootW-2:0], 1'b0};
      end
    end
  end

  // lowest index wins on equal roots
  always_comb begin
    logic [RootW-1:0] best_root;
    best_idx  = '0;
    best_root = root_q[0];
    for (int n = 1; n < NumColors; n++) begin
      if (root_q[n] < best_root) begin
        best_idx  = IdxW'(n);
        best_root = root_q[n];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      F_IDLE: if (in_valid_i) state_d = F_SQR;
      F_SQR:  state_d = F_SUM;
      F_SUM: begin
        state_d = F_ROOT;
        step_d  = '0;
      end
      F_ROOT: begin
        if (step_q == StepW'(RootSteps - 1)) begin
          state_d = F_PICK;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      F_PICK: if (push_ready_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        pix_q[0] <= red_i;
        pix_q[1] <= green_i;
        pix_q[2] <= blue_i;
        last_q   <= end_of_image_i;
      end
      F_SQR: sq_q <= sq_d;
      F_SUM: begin
        for (int n = 0; n < NumColors; n++) begin
          rad_q[n]  <= RadW'(sq_q[n][0]) + RadW'(sq_q[n][1]) + RadW'(sq_q[n][2]);
          rem_q[n]  <= '0;
          root_q[n] <= '0;
        end
      end
      F_ROOT: begin
        rad_q  <= rad_d;
        rem_q  <= rem_d;
        root_q <= root_d;
      end
      default: ;
    endcase
  end

  assign in_ready_o       = (state_q == F_IDLE);
  assign push_valid_o     = (state_q == F_PICK);
  assign push_data_o.idx  = best_idx;
  assign push_data_o.last = last_q;

endmodule

@@ hdl/pqp_fifo.sv @@
module pqp_fifo
  import pqp_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  pqp_entry_t push_data_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output pqp_entry_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pqp_entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ hdl/pqp_back.sv @@
module pqp_back
  import pqp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  pqp_entry_t       pop_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] packed_byte_o,
  output logic             final_byte_o
);

  logic [PendW-1:0]    pend_bits_q;
  logic [PendCntW-1:0] pend_cnt_q;
  logic                out_valid_q;
  logic [ByteW-1:0]    out_byte_q;
  logic                out_final_q;
  logic                pop;
  logic                emit;
  logic [ByteW-1:0]    byte_new;

  // output slot free or being drained this cycle
  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign pop  = pop_valid_i && pop_ready_o;
  assign byte_new = {2'b00, pend_bits_q}
                  | (ByteW'(pop_data_i.idx) << {pend_cnt_q, 1'b0});
  assign emit = (pend_cnt_q == PendCntW'(3)) || pop_data_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i) out_valid_q <= 1'b0;
      if (pop) begin
        if (emit) begin
          out_valid_q <= 1'b1;
          pend_bits_q <= '0;
          pend_cnt_q  <= '0;
        end else begin
          pend_bits_q <= byte_new[PendW-1:0];
          pend_cnt_q  <= pend_cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && emit) begin
      out_byte_q  <= byte_new;
      out_final_q <= pop_data_i.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign packed_byte_o = out_byte_q;
  assign final_byte_o  = out_final_q;

endmodule

@@ hdl/palette_quantize_pack_2bpp.sv @@
// Nearest-palette quantiser with 2 bit per pixel packing.
// Input channel (in_valid_i / in_ready_o): one RGB pixel per item plus an
// end_of_image_i flag on the last pixel of an image. Output channel
// (out_valid_o / out_ready_i): one packed byte, first pixel in bits 1:0, with
// final_byte_o set on the last byte of the image; a partial byte at the end
// of an image is zero-padded. Every fourth pixel and every end-of-image pixel
// yields a byte, other pixels yield nothing.
// cfg_we_i / cfg_data_i write palette_mode: 0 texture, 1 sprite palette.
// Write it only while the block is idle.
// The classifier takes a new pixel only once it is done with the last one: it
// squares the channel distances, sums them, runs a bit-serial square root,
// picks the nearest colour and then goes idle to take the next pixel.
// A byte passes from the classifier through the queue and the packer into
// the output register.
// A queue of QueueDepth entries lets the classifier keep going while the
// receiver stalls; once it is full the classifier holds and in_ready_o stays
// low. Reset clears the packer, the queue and the output valid flag and
// selects the texture palette.
module palette_quantize_pack_2bpp
  import pqp_pkg::*;
#(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ChanW-1:0] red_i,
  input  logic [ChanW-1:0] green_i,
  input  logic [ChanW-1:0] blue_i,
  input  logic             end_of_image_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] packed_byte_o,
  output logic             final_byte_o
);

  logic       palette_mode_q;
  logic       push_valid, push_ready;
  pqp_entry_t push_data;
  logic       pop_valid, pop_ready;
  pqp_entry_t pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_mode_q <= PalTexture;
    end else if (cfg_we_i) begin
      palette_mode_q <= cfg_data_i;
    end
  end

  pqp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .palette_mode_i (palette_mode_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .end_of_image_i (end_of_image_i),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_data_o    (push_data)
  );

  pqp_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  pqp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_data_i    (pop_data),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .packed_byte_o (packed_byte_o),
    .final_byte_o  (final_byte_o)
  );

endmodule

@@ tb/palette_quantize_pack_2bpp_tb.sv @@
module palette_quantize_pack_2bpp_tb
  import pqp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned SettleCycles = 30;
  localparam int unsigned NumPhases    = 6;
  localparam int unsigned PhaseItems   = 240;
  localparam int unsigned NumDirected  = 14;

  // colours are {red, green, blue}
  localparam logic [23:0] DirPx [NumDirected] = '{
    24'h000000, 24'hFFFFFF, 24'hBFBFBF, 24'h7F7F7F,
    24'h00FFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
    24'hDFDFDF, 24'h404040, 24'h80FFFF, 24'hFFFF00,
    24'hFF00FF, 24'h7FFFFF
  };
  // full byte, full byte ending the image, then flushes of one, two and three pixels
  localparam bit DirEoi [NumDirected] = '{
    1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b1, 1'b0, 1'b1, 1'b0,
    1'b0, 1'b1
  };

  function automatic logic [23:0] colour_of(logic pal, int unsigned n);
    case (n)
      0: return (pal == PalSprite) ? 24'h00FFFF : 24'hBFBFBF;
      1: return 24'hFFFFFF;
      2: return 24'h000000;
      default: return 24'h7F7F7F;
    endcase
  endfunction

  typedef struct packed {
    logic [ByteW-1:0] bits;
    logic             last;
  } packed_out_t;

  class pixel_scoreboard;
    logic                pal_mode;
    logic [PendW-1:0]    held_bits;
    logic [PendCntW-1:0] held_cnt;
    packed_out_t         due_bytes[$];
    int unsigned         mismatches;
    int unsigned         pixels_in;
    int unsigned         bytes_seen;
    int unsigned         image_ends;

    function automatic int unsigned floor_root(int unsigned v);
      int unsigned r;
      int unsigned t;
      r = 0;
      for (int b = 9; b >= 0; b--) begin
        t = r | (32'd1 << b);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    function automatic logic [IdxW-1:0] nearest(logic [7:0] r, logic [7:0] g,
                                                 logic [7:0] b);
      logic [23:0]     c;
      int              dr;
      int              dg;
      int              db;
      int unsigned     d;
      int unsigned     best_d;
      logic [IdxW-1:0] best;
      best = '0;
      best_d = 0;
      for (int n = 0; n < NumColors; n++) begin
        c = colour_of(pal_mode, n);
        dr = int'(c[23:16]) - int'(r);
        dg = int'(c[15:8]) - int'(g);
        db = int'(c[7:0]) - int'(b);
        d = floor_root(dr * dr + dg * dg + db * db);
        // strict compare keeps the lower index on a tie
        if (n == 0 || d < best_d) begin
          best = n[IdxW-1:0];
          best_d = d;
        end
      end
      return best;
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic eoi);
      logic [ByteW-1:0] whole;
      packed_out_t      entry;
      whole = {{(ByteW-IdxW){1'b0}}, nearest(r, g, b)};
      whole = (whole << (2 * held_cnt)) | {{(ByteW-PendW){1'b0}}, held_bits};
      pixels_in++;
      if (held_cnt == 2'd3 || eoi) begin
        entry.bits = whole;
        entry.last = eoi;
        due_bytes = {due_bytes, entry};
        if (eoi) image_ends++;
        held_bits = '0;
        held_cnt = '0;
      end else begin
        held_bits = whole[PendW-1:0];
        held_cnt = held_cnt + 1'b1;
      end
    endfunction

    function void check_byte(logic [ByteW-1:0] bits, logic last);
      packed_out_t want;
      bytes_seen++;
      if (due_bytes.size() == 0) begin
        $display("%0t: unexpected byte %02h final %0b", $time, bits, last);
        mismatches++;
        return;
      end
      want = due_bytes.pop_front();
      if (want.bits !== bits) begin
        $display("%0t: packed byte expected %02h, got %02h", $time, want.bits, bits);
        mismatches++;
      end
      if (want.last !== last) begin
        $display("%0t: final flag expected %0b, got %0b", $time, want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic             cfg_data_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [ChanW-1:0] red_i;
  logic [ChanW-1:0] green_i;
  logic [ChanW-1:0] blue_i;
  logic             end_of_image_i;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [ByteW-1:0] packed_byte_o;
  logic             final_byte_o;

  pixel_scoreboard sb = new();
  bit              calm;
  int unsigned     cycles = 0;

  palette_quantize_pack_2bpp uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .end_of_image_i(end_of_image_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .packed_byte_o (packed_byte_o),
    .final_byte_o  (final_byte_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      sb.note_pixel(red_i, green_i, blue_i, end_of_image_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_byte(packed_byte_o, final_byte_o);
    end
    out_ready_i <= calm || ($urandom_range(99) >= 33);
  end

  function automatic logic [23:0] pick_colour(logic pal);
    logic [23:0] base;
    logic [23:0] other;
    logic [23:0] px;
    int          v;
    int unsigned spread;
    case ($urandom_range(3))
      0, 1: return 24'($urandom());
      2: begin
        base = colour_of(pal, $urandom_range(3));
        other = base;
        spread = 12;
      end
      default: begin
        // near the midpoint of two entries, where floored distances can tie
        base = colour_of(pal, $urandom_range(3));
        other = colour_of(pal, $urandom_range(3));
        spread = 2;
      end
    endcase
    for (int ch = 0; ch < 3; ch++) begin
      v = (int'(base[8*ch +: 8]) + int'(other[8*ch +: 8])) / 2;
      v = v + int'($urandom_range(2 * spread)) - int'(spread);
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      px[8*ch +: 8] = v[7:0];
    end
    return px;
  endfunction

  task automatic send_pixel(logic [23:0] px, logic eoi);
    while (!calm && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    red_i          <= px[23:16];
    green_i        <= px[15:8];
    blue_i         <= px[7:0];
    end_of_image_i <= eoi;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // hold the sender until all bytes are out and the classifier has gone quiet
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.due_bytes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_palette(logic pal);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= pal;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.pal_mode = pal;
  endtask

  task automatic random_images(int unsigned count);
    int unsigned left;
    int unsigned len;
    logic        eoi;
    left = count;
    while (left > 0) begin
      len = $urandom_range(1, 12);
      if (len > left) len = left;
      for (int unsigned k = 1; k <= len; k++) begin
        // a few stray end-of-image flags break images up early or drop an image end
        if ($urandom_range(9) == 0) eoi = 1'($urandom_range(1));
        else eoi = (k == len);
        send_pixel(pick_colour(sb.pal_mode), eoi);
      end
      left -= len;
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_data_i     = 1'b0;
    in_valid_i     = 1'b0;
    red_i          = '0;
    green_i        = '0;
    blue_i         = '0;
    end_of_image_i = 1'b0;
    calm           = 1'b0;
    sb.pal_mode    = PalTexture;
    sb.held_bits   = '0;
    sb.held_cnt    = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) send_pixel(DirPx[i], DirEoi[i]);
    set_palette(PalSprite);
    for (int i = 0; i < 9; i++) send_pixel(DirPx[i], DirEoi[i]);

    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      if (ph == 0 || ph == 1) set_palette(ph[0] ? PalSprite : PalTexture);
      else set_palette(1'($urandom_range(1)));
      calm = (ph == 3);
      random_images(PhaseItems);
    end
    calm = 1'b0;

    drain();
    if (sb.due_bytes.size() != 0) begin
      $display("%0d expected bytes never arrived", sb.due_bytes.size());
    end
    $display("covered %0d pixels and %0d bytes, %0d of them ending an image,",
             sb.pixels_in, sb.bytes_seen, sb.image_ends);
    $display("over both palettes with stalls on either side and a stall-free stretch");
    if (sb.mismatches == 0 && sb.due_bytes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ palette_quantize_pack_2bpp.f @@
hdl/pqp_pkg.sv
hdl/pqp_front.sv
hdl/pqp_fifo.sv
hdl/pqp_back.sv
hdl/palette_quantize_pack_2bpp.sv
tb/palette_quantize_pack_2bpp_tb.sv
